// ===== sv/ttce_pkg.sv =====
// Shared types and constants for the character-cell text terminal engine.
// Holds the request and result payload structs, op and control-code names.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ttce_pkg;

  localparam int ROWS_DEF = 32;
  localparam int COLS_DEF = 32;

  localparam int          PADDR_W        = 3;
  localparam logic        REG_VIEW_LINES = 1'b0;
  localparam logic [5:0]  VIEW_RESET     = 6'd9;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_NL    = 8'hF0;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_BS    = 8'hF1;
  localparam logic [7:0] CH_EOL   = 8'hF2;
  localparam logic [7:0] CH_SPACE = 8'hF4;
  localparam logic [7:0] BLANK    = 8'h20;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_MOVE  = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAN = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_WALK
  } state_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] char_code;
    logic [4:0] target_col;
    logic [4:0] target_line;
  } req_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic       line_dirty;
    logic [4:0] cursor_row;
    logic [4:0] cursor_column;
    logic [4:0] top_visible_line;
  } res_t;

endpackage

`default_nettype wire

// ===== sv/text_terminal_char_engine.sv =====
// Top level of the character-cell text terminal engine.
// Instantiates ttce_cellmem and uses the types and constants of ttce_pkg.
`timescale 1ns / 1ps
`default_nettype none

// A request is taken at a rising edge where start is high and busy is low. It
// carries an op (put character, move cursor, read cell, mark line clean) and
// its operands. Every request produces exactly one result, which sits on
// result_o for one cycle while result_valid_o is high; the receiver has no
// way to hold it off, so it must sample it in that cycle.
// For most requests, the acceptance cycle reads the character and fill-extent
// memories, and the next cycle finishes the read-modify-write and registers
// the result, which is shown in the following cycle while the next request
// can already be taken. A printable character written past the filled part
// of its row goes through the gap-blanking state first: the cells in between
// are blanked one at a time through the single memory write port before the
// character itself is written.
// Scrolling rotates a ring base instead of moving the buffer, and a cleared
// row is marked by dropping its valid bit, so neither scroll nor clear-screen
// walks the memory. Erase-to-end-of-line just shortens the row's fill extent.
// Reset empties all rows (they read as spaces), marks every line dirty, homes
// the cursor and window and sets view_lines to nine; the block is usable in
// the first cycle after reset. view_lines is written through the APB port,
// which should only be done while busy is low and no result is pending.

module text_terminal_char_engine
  import ttce_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire req_t               req_i,
  output logic                    result_valid_o,
  output res_t                    result_o,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready
);

  localparam int LW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam int BW = $clog2(COLS + 1);
  localparam int SW = ((LW > 6) ? LW : 6) + 1;

  // Maps a logical line onto its physical memory row through the ring base.
  function automatic logic [LW-1:0] phys_row(input logic [LW-1:0] line,
                                             input logic [LW-1:0] base);
    logic [LW:0] sum;
    sum = {1'b0, line} + {1'b0, base};
    if (sum >= (LW+1)'(ROWS)) begin
      sum = sum - (LW+1)'(ROWS);
    end
    return sum[LW-1:0];
  endfunction

  function automatic logic [LW-1:0] sat_line(input logic [4:0] v);
    if (32'(v) < ROWS) begin
      return LW'(v);
    end
    return LW'(ROWS - 1);
  endfunction

  function automatic logic [CW-1:0] sat_col(input logic [4:0] v);
    if (32'(v) < COLS) begin
      return CW'(v);
    end
    return CW'(COLS - 1);
  endfunction

  state_e          state_q, state_d;
  req_t            req_q;
  logic [LW-1:0]   cur_line_q, cur_line_d;
  logic [CW-1:0]   cur_col_q, cur_col_d;
  logic [LW-1:0]   top_q, top_d;
  logic [LW-1:0]   base_q, base_d;
  logic [5:0]      view_lines_q;
  logic [ROWS-1:0] dirty_q, dirty_d;
  logic [ROWS-1:0] rowok_q, rowok_d;
  logic [BW-1:0]   walk_q, walk_d;
  res_t            res_q, res_d;
  logic            done_q, done_d;

  logic            accept;
  logic            cfg_write;
  logic [LW-1:0]   rd_row;
  logic [7:0]      rd_char;
  logic [BW-1:0]   rd_fill;
  logic            wr_en;
  logic [LW-1:0]   wr_row;
  logic [CW-1:0]   wr_col;
  logic [7:0]      wr_char;
  logic            fill_we;
  logic [BW-1:0]   fill_val;

  logic [LW-1:0]   cur_phys;
  logic [BW-1:0]   fill_eff;
  logic [BW-1:0]   col_ext;
  logic [7:0]      put_code;
  logic            is_char;
  logic            finish;
  logic [LW-1:0]   tline_sat;
  logic [CW-1:0]   tcol_sat;
  logic [LW-1:0]   tline_phys;
  logic [LW:0]     line_w;
  logic [LW-1:0]   line_fin;
  logic [CW-1:0]   col_w;
  logic [LW-1:0]   top_w;
  logic            mark_all;
  logic [5:0]      shown;
  logic [SW-1:0]   line_p1;
  logic [SW-1:0]   win_end;

  assign accept    = start && !busy;
  assign busy      = (state_q != ST_IDLE);
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_VIEW_LINES) ? {26'd0, view_lines_q} : 32'd0;

  // At acceptance the memories are read at the row the request touches: the
  // target cell for a read, the cursor row for anything else.
  assign rd_row = (req_i.op == OP_READ) ? phys_row(sat_line(req_i.target_line), base_q)
                                        : phys_row(cur_line_q, base_q);

  ttce_cellmem #(
    .ROWS(ROWS),
    .COLS(COLS)
  ) u_cellmem (
    .clk_i      (clk_i),
    .rd_en_i    (accept),
    .rd_row_i   (rd_row),
    .rd_col_i   (sat_col(req_i.target_col)),
    .rd_char_o  (rd_char),
    .rd_fill_o  (rd_fill),
    .wr_en_i    (wr_en),
    .wr_row_i   (wr_row),
    .wr_col_i   (wr_col),
    .wr_char_i  (wr_char),
    .fill_we_i  (fill_we),
    .fill_row_i (cur_phys),
    .fill_val_i (fill_val)
  );

  // Operands of the request under work. A row whose valid bit is clear is
  // empty regardless of what the fill memory still holds for it.
  assign cur_phys   = phys_row(cur_line_q, base_q);
  assign fill_eff   = rowok_q[cur_phys] ? rd_fill : '0;
  assign col_ext    = BW'(cur_col_q);
  assign put_code   = (req_q.char_code == CH_SPACE) ? BLANK : req_q.char_code;
  assign tline_sat  = sat_line(req_q.target_line);
  assign tcol_sat   = sat_col(req_q.target_col);
  assign tline_phys = phys_row(tline_sat, base_q);
  assign shown      = (view_lines_q == 6'd0) ? 6'd1 : view_lines_q;

  always_comb begin
    is_char = (req_q.op == OP_PUT);
    case (req_q.char_code) inside
      CH_CR, CH_LF, CH_NL, CH_FF, CH_BS, CH_EOL: is_char = 1'b0;
      default: ;
    endcase
  end

  // A character beyond the filled extent first has the gap blanked.
  assign finish = ((state_q == ST_EXEC) && !(is_char && (fill_eff < col_ext))) ||
                  ((state_q == ST_WALK) && (walk_q == col_ext));

  // Next state, memory writes and the step's effect on cursor, window and flags.
  always_comb begin
    state_d  = state_q;
    walk_d   = walk_q;
    done_d   = 1'b0;
    res_d    = res_q;
    wr_en    = 1'b0;
    wr_row   = cur_phys;
    wr_col   = CW'(walk_q);
    wr_char  = BLANK;
    fill_we  = 1'b0;
    fill_val = '0;
    line_w   = {1'b0, cur_line_q};
    col_w    = cur_col_q;
    top_w    = top_q;
    base_d   = base_q;
    rowok_d  = rowok_q;
    dirty_d  = dirty_q;
    mark_all = 1'b0;
    line_fin = cur_line_q;
    line_p1  = '0;
    win_end  = '0;
    res_d.cell_char  = 8'd0;
    res_d.line_dirty = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!finish) begin
          state_d = ST_WALK;
          walk_d  = fill_eff;
        end
      end
      ST_WALK: begin
        if (!finish) begin
          wr_en  = 1'b1;
          walk_d = walk_q + BW'(1);
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (finish) begin
      state_d = ST_IDLE;
      done_d  = 1'b1;
      case (req_q.op)
        OP_PUT: begin
          case (req_q.char_code) inside
            CH_CR, CH_LF, CH_NL: begin
              line_w = line_w + (LW+1)'(1);
              col_w  = '0;
            end
            CH_FF: begin
              rowok_d  = '0;
              mark_all = 1'b1;
              top_w    = '0;
              line_w   = '0;
              col_w    = '0;
            end
            CH_BS: begin
              if (cur_col_q != '0) begin
                col_w = cur_col_q - CW'(1);
              end else if (cur_line_q != '0) begin
                line_w = line_w - (LW+1)'(1);
                col_w  = CW'(COLS - 1);
              end
              wr_en   = 1'b1;
              wr_row  = phys_row(line_w[LW-1:0], base_q);
              wr_col  = col_w;
              wr_char = BLANK;
              dirty_d[line_w[LW-1:0]] = 1'b1;
              if (line_w < {1'b0, top_q}) begin
                top_w    = line_w[LW-1:0];
                mark_all = 1'b1;
              end
            end
            CH_EOL: begin
              fill_we  = 1'b1;
              fill_val = (fill_eff < col_ext) ? fill_eff : col_ext;
              rowok_d[cur_phys]   = 1'b1;
              dirty_d[cur_line_q] = 1'b1;
            end
            default: begin
              wr_en   = 1'b1;
              wr_row  = cur_phys;
              wr_col  = cur_col_q;
              wr_char = put_code;
              if (!(col_ext < fill_eff)) begin
                fill_we  = 1'b1;
                fill_val = col_ext + BW'(1);
                rowok_d[cur_phys] = 1'b1;
              end
              dirty_d[cur_line_q] = 1'b1;
              if (cur_col_q == CW'(COLS - 1)) begin
                line_w = line_w + (LW+1)'(1);
                col_w  = '0;
              end else begin
                col_w = cur_col_q + CW'(1);
              end
            end
          endcase
          // Running off the last row scrolls: the top physical row becomes the
          // new, empty bottom row.
          if (line_w == (LW+1)'(ROWS)) begin
            base_d   = (base_q == LW'(ROWS - 1)) ? '0 : base_q + LW'(1);
            rowok_d[base_q] = 1'b0;
            mark_all = 1'b1;
            line_w   = (LW+1)'(ROWS - 1);
          end
          line_fin = line_w[LW-1:0];
          line_p1  = SW'(line_fin) + SW'(1);
          win_end  = SW'(top_w) + SW'(shown);
          // After a put the window moves down if needed, so the cursor is on or above its last line.
          if (line_p1 >= win_end) begin
            mark_all = 1'b1;
            top_w    = LW'(line_p1 - SW'(shown));
          end
        end
        OP_MOVE: begin
          line_fin = tline_sat;
          col_w    = tcol_sat;
          line_p1  = SW'(line_fin) + SW'(1);
          win_end  = SW'(top_w) + SW'(shown);
          if (line_p1 > win_end) begin
            mark_all = 1'b1;
            top_w    = LW'(line_p1 - SW'(shown));
          end
        end
        OP_READ: begin
          if ((32'(req_q.target_line) < ROWS) && (32'(req_q.target_col) < COLS)) begin
            res_d.cell_char  = (rowok_q[tline_phys] && (BW'(tcol_sat) < rd_fill))
                               ? rd_char : BLANK;
            res_d.line_dirty = dirty_q[tline_sat];
          end
        end
        OP_CLEAN: begin
          if (32'(req_q.target_line) < ROWS) begin
            dirty_d[tline_sat] = 1'b0;
          end
        end
        default: ;
      endcase
      if (mark_all) begin
        dirty_d = '1;
      end
      res_d.cursor_row       = 5'(line_fin);
      res_d.cursor_column    = 5'(col_w);
      res_d.top_visible_line = 5'(top_w);
    end

    cur_line_d = finish ? line_fin : cur_line_q;
    cur_col_d  = finish ? col_w : cur_col_q;
    top_d      = finish ? top_w : top_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cur_line_q   <= '0;
      cur_col_q    <= '0;
      top_q        <= '0;
      base_q       <= '0;
      view_lines_q <= VIEW_RESET;
      dirty_q      <= '1;
      rowok_q      <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_line_q <= cur_line_d;
      cur_col_q  <= cur_col_d;
      top_q      <= top_d;
      base_q     <= base_d;
      dirty_q    <= dirty_d;
      rowok_q    <= rowok_d;
      done_q     <= done_d;
      if (cfg_write && (paddr[2] == REG_VIEW_LINES)) begin
        view_lines_q <= pwdata[5:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    walk_q <= walk_d;
    res_q  <= res_d;
  end

  assign result_valid_o = done_q;
  assign result_o       = res_q;

  // Every accepted request starts work in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted request did not start work");

  // A result is only produced by a request that was under work.
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(state_q != ST_IDLE))
    else $error("result without a request");

  // Gap blanking is entered only from the execute cycle or continues itself.
  a_walk_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> ($past(state_q) == ST_EXEC || $past(state_q) == ST_WALK))
    else $error("gap blanking entered from idle");

  // The blanking pointer never passes the cursor column it is filling up to.
  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (walk_q <= col_ext))
    else $error("gap blanking ran past the cursor");

  // The cursor reported with a result lies inside the buffer.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ((32'(cur_line_q) < ROWS) && (32'(cur_col_q) < COLS)))
    else $error("cursor outside the buffer");

endmodule

`default_nettype wire

// ===== sv/ttce_cellmem.sv =====
// Character memory and per-row fill-extent memory of the terminal engine.
// Both are synchronous single-port-write, single-read memories.
// Depends on ttce_pkg for default sizes.
`timescale 1ns / 1ps
`default_nettype none

module ttce_cellmem
  import ttce_pkg::*;
#(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF,
  localparam int LW = $clog2(ROWS),
  localparam int CW = $clog2(COLS),
  localparam int BW = $clog2(COLS + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rd_en_i,
  input  wire logic [LW-1:0] rd_row_i,
  input  wire logic [CW-1:0] rd_col_i,
  output logic      [7:0]    rd_char_o,
  output logic      [BW-1:0] rd_fill_o,
  input  wire logic          wr_en_i,
  input  wire logic [LW-1:0] wr_row_i,
  input  wire logic [CW-1:0] wr_col_i,
  input  wire logic [7:0]    wr_char_i,
  input  wire logic          fill_we_i,
  input  wire logic [LW-1:0] fill_row_i,
  input  wire logic [BW-1:0] fill_val_i
);

  logic [7:0]    char_mem [ROWS][COLS];
  logic [BW-1:0] fill_mem [ROWS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      char_mem[wr_row_i][wr_col_i] <= wr_char_i;
    end
    if (rd_en_i) begin
      rd_char_o <= char_mem[rd_row_i][rd_col_i];
    end
  end

  // The fill extent says how many leading cells of a row hold written data.
  always_ff @(posedge clk_i) begin
    if (fill_we_i) begin
      fill_mem[fill_row_i] <= fill_val_i;
    end
    if (rd_en_i) begin
      rd_fill_o <= fill_mem[rd_row_i];
    end
  end

endmodule

`default_nettype wire
